@@ rtl/core/gfpse_pkg.sv @@
// gfpse_pkg: shared types, field widths, register codes and GF(2^8) helpers
// for the parity shard encoder core. No dependencies; every other file imports it.
package gfpse_pkg;

  // Default sizing handed to the top level
  localparam int MAX_DATA_SHARDS_DEF   = 16;
  localparam int MAX_PARITY_SHARDS_DEF = 8;
  localparam int SHARD_BYTES_DEF       = 2048;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int SHARD_W     = 4;
  localparam int POS_W       = 11;
  localparam int PIDX_W      = 3;
  localparam int DCOUNT_W    = 5;
  localparam int PCOUNT_W    = 4;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_DATA   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_PARITY = 1'b1;

  // Register reset values
  localparam logic [DCOUNT_W-1:0] NUM_DATA_RST   = 5'd5;
  localparam logic [PCOUNT_W-1:0] NUM_PARITY_RST = 4'd2;

  // GF(2^8) field: polynomial x^8+x^4+x^3+x^2+1, multiplicative group order
  localparam logic [8:0] GF_POLY  = 9'h11d;
  localparam logic [8:0] GF_ORDER = 9'd255;

  // One input beat
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [SHARD_W-1:0] shard_index;
    logic [POS_W-1:0]   byte_pos;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [PIDX_W-1:0] parity_index;
    logic [POS_W-1:0]  out_pos;
    logic [BYTE_W-1:0] parity_byte;
    logic              last;
  } out_beat_t;

  // Item travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic               fresh;   // shard 0: overwrite accumulator
    logic               emit;    // last data shard: results leave at chain end
    logic [BYTE_W-1:0]  data_byte;
    logic [SHARD_W-1:0] shard;
    logic [POS_W-1:0]   pos;
  } item_t;

  typedef logic [255:0][BYTE_W-1:0] gf_tab_t;

  // Antilog table, generator 2
  function automatic gf_tab_t gf_exp_build();
    gf_tab_t    t;
    logic [8:0] e;
    e = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = e[7:0];
      e = {e[7:0], 1'b0};
      if (e[8]) e = e ^ GF_POLY;
    end
    return t;
  endfunction

  // Log table, entry for zero unused
  function automatic gf_tab_t gf_log_build();
    gf_tab_t    t;
    logic [8:0] e;
    t = '0;
    e = 9'd1;
    for (int i = 0; i < 255; i++) begin
      t[e[7:0]] = 8'(i);
      e = {e[7:0], 1'b0};
      if (e[8]) e = e ^ GF_POLY;
    end
    return t;
  endfunction

  localparam gf_tab_t GF_EXP = gf_exp_build();
  localparam gf_tab_t GF_LOG = gf_log_build();

  // Shift-and-add GF(2^8) multiply, eight narrow steps
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] r;
    x = a;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) r = r ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/gfpse_ifs.sv @@
// gfpse_ifs: valid/ready channel interfaces for data input and parity output.
// Depends on gfpse_pkg for the beat types.
interface gfpse_in_if;
  import gfpse_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface gfpse_out_if;
  import gfpse_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

@@ rtl/core/gfpse_front.sv @@
// gfpse_front: configuration registers, input register and range check stage
// that feeds the cell chain. Depends on gfpse_pkg.
module gfpse_front #(
  parameter int MAX_DATA_SHARDS   = gfpse_pkg::MAX_DATA_SHARDS_DEF,
  parameter int MAX_PARITY_SHARDS = gfpse_pkg::MAX_PARITY_SHARDS_DEF,
  parameter int SHARD_BYTES       = gfpse_pkg::SHARD_BYTES_DEF,
  parameter int PC_W              = $clog2(MAX_PARITY_SHARDS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                cfg_we,
  input  logic [gfpse_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gfpse_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  input  gfpse_pkg::in_beat_t                 in_beat,
  output gfpse_pkg::item_t                    item_out,
  output logic [gfpse_pkg::DCOUNT_W-1:0]      num_data,
  output logic [PC_W-1:0]                     pc_sat,
  output logic [MAX_PARITY_SHARDS-1:0]        row_active
);
  import gfpse_pkg::*;

  logic [PCOUNT_W-1:0] num_parity;
  logic                s0_valid;
  in_beat_t            s0_beat;
  logic                chk_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_data   <= NUM_DATA_RST;
      num_parity <= NUM_PARITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_DATA:   num_data   <= cfg_data[DCOUNT_W-1:0];
        REG_NUM_PARITY: num_parity <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Parity rows in use, saturated to the cell count
  assign pc_sat = (32'(num_parity) > MAX_PARITY_SHARDS) ? PC_W'(MAX_PARITY_SHARDS)
                                                        : PC_W'(num_parity);

  for (genvar r = 0; r < MAX_PARITY_SHARDS; r++) begin : g_row
    assign row_active[r] = (r < 32'(pc_sat));
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_beat <= in_beat;
    end
  end

  // Range check
  assign chk_ok = (DCOUNT_W'(s0_beat.shard_index) < num_data) &&
                  (32'(s0_beat.shard_index) < MAX_DATA_SHARDS) &&
                  (32'(s0_beat.byte_pos) < SHARD_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= s0_valid && chk_ok;
    end
    if (en) begin
      item_out.fresh     <= (s0_beat.shard_index == '0);
      item_out.emit      <= (DCOUNT_W'(s0_beat.shard_index) + DCOUNT_W'(1) == num_data);
      item_out.data_byte <= s0_beat.data_byte;
      item_out.shard     <= s0_beat.shard_index;
      item_out.pos       <= s0_beat.byte_pos;
    end
  end

endmodule

@@ rtl/core/gfpse_cell.sv @@
// gfpse_cell: one parity row. Holds that row's accumulator memory, multiplies the
// passing byte by its Vandermonde coefficient and hands the item on. Depends on gfpse_pkg.
module gfpse_cell #(
  parameter int CELL_IDX          = 0,
  parameter int MAX_PARITY_SHARDS = gfpse_pkg::MAX_PARITY_SHARDS_DEF,
  parameter int SHARD_BYTES       = gfpse_pkg::SHARD_BYTES_DEF,
  parameter int ADDR_W            = (SHARD_BYTES > 1) ? $clog2(SHARD_BYTES) : 1
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              active,
  input  logic [gfpse_pkg::DCOUNT_W-1:0]                    num_data,
  input  gfpse_pkg::item_t                                  item_in,
  input  logic [MAX_PARITY_SHARDS-1:0][gfpse_pkg::BYTE_W-1:0] par_in,
  output gfpse_pkg::item_t                                  item_out,
  output logic [MAX_PARITY_SHARDS-1:0][gfpse_pkg::BYTE_W-1:0] par_out
);
  import gfpse_pkg::*;

  logic [BYTE_W-1:0] acc_mem [SHARD_BYTES];

  logic [BYTE_W-1:0] x_val;
  logic [BYTE_W-1:0] log_x;
  logic              x_zero;

  logic [11:0]       lprod;
  logic [8:0]        lsum;
  logic [BYTE_W-1:0] lidx;
  logic [BYTE_W-1:0] coef_next;

  item_t                                  a_item;
  logic [MAX_PARITY_SHARDS-1:0][BYTE_W-1:0] a_par;
  logic [BYTE_W-1:0]                      a_coef;
  logic [BYTE_W-1:0]                      rd_data;
  logic [ADDR_W-1:0]                      in_addr;
  logic [ADDR_W-1:0]                      a_addr;

  logic              byp_valid;
  logic [ADDR_W-1:0] byp_addr;
  logic [BYTE_W-1:0] byp_data;

  logic              wr_en;
  logic [BYTE_W-1:0] acc_old;
  logic [BYTE_W-1:0] acc_new;
  logic [MAX_PARITY_SHARDS-1:0][BYTE_W-1:0] par_next;

  // Row base x = num_data + row + 1, kept as its log
  assign x_val = BYTE_W'(32'(num_data) + CELL_IDX + 1);

  always_ff @(posedge clk) begin
    log_x  <= GF_LOG[x_val];
    x_zero <= (x_val == '0);
  end

  // Coefficient x^shard through log/antilog, exponent folded mod 255
  always_comb begin
    lprod = 12'(log_x) * 12'(item_in.shard);
    lsum  = 9'(lprod[7:0]) + 9'(lprod[11:8]);
    lidx  = (lsum >= GF_ORDER) ? BYTE_W'(lsum - GF_ORDER) : lsum[7:0];
    if (x_zero) begin
      coef_next = (item_in.shard == '0) ? 8'd1 : 8'd0;
    end else begin
      coef_next = GF_EXP[lidx];
    end
  end

  assign in_addr = ADDR_W'(item_in.pos);
  assign a_addr  = ADDR_W'(a_item.pos);

  // Stage A: capture item, coefficient and accumulator read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_item.valid <= 1'b0;
    end else if (en) begin
      a_item.valid <= item_in.valid;
    end
    if (en) begin
      a_item.fresh     <= item_in.fresh;
      a_item.emit      <= item_in.emit;
      a_item.data_byte <= item_in.data_byte;
      a_item.shard     <= item_in.shard;
      a_item.pos       <= item_in.pos;
      a_par            <= par_in;
      a_coef           <= coef_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= acc_mem[in_addr];
    end
  end

  // Read-modify-write; bypass covers the write made one beat earlier
  assign wr_en   = en && a_item.valid && active;
  assign acc_old = (byp_valid && (byp_addr == a_addr)) ? byp_data : rd_data;
  assign acc_new = (a_item.fresh ? '0 : acc_old) ^ gf_mul(a_item.data_byte, a_coef);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[a_addr] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (en) begin
      byp_valid <= a_item.valid && active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_addr <= a_addr;
      byp_data <= acc_new;
    end
  end

  // This row's byte dropped into its slot
  always_comb begin
    par_next = a_par;
    if (active) begin
      par_next[CELL_IDX] = acc_new;
    end
  end

  // Stage B: hand on, with this row's byte in its slot
  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= a_item.valid;
    end
    if (en) begin
      item_out.fresh     <= a_item.fresh;
      item_out.emit      <= a_item.emit;
      item_out.data_byte <= a_item.data_byte;
      item_out.shard     <= a_item.shard;
      item_out.pos       <= a_item.pos;
      par_out            <= par_next;
    end
  end

endmodule

@@ rtl/core/gfpse_drain.sv @@
// gfpse_drain: output register at the chain end; turns one finished item into
// one parity beat per row, in row order. Depends on gfpse_pkg.
module gfpse_drain #(
  parameter int MAX_PARITY_SHARDS = gfpse_pkg::MAX_PARITY_SHARDS_DEF,
  parameter int PC_W              = $clog2(MAX_PARITY_SHARDS + 1),
  parameter int IDX_W             = (MAX_PARITY_SHARDS > 1) ? $clog2(MAX_PARITY_SHARDS) : 1
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  gfpse_pkg::item_t                                    tail_item,
  input  logic [MAX_PARITY_SHARDS-1:0][gfpse_pkg::BYTE_W-1:0] tail_par,
  input  logic [PC_W-1:0]                                     pc_sat,
  output logic                                                en,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output gfpse_pkg::out_beat_t                                out_beat
);
  import gfpse_pkg::*;

  logic                                   busy;
  logic [IDX_W-1:0]                       idx;
  logic [IDX_W-1:0]                       last_idx;
  logic [POS_W-1:0]                       pos;
  logic [MAX_PARITY_SHARDS-1:0][BYTE_W-1:0] bytes;

  logic need;
  logic beat_done;
  logic run_done;
  logic can_load;
  logic load;

  // Chain may move unless its tail holds results that cannot be taken yet
  assign need      = tail_item.valid && tail_item.emit && (pc_sat != '0);
  assign beat_done = busy && out_ready;
  assign run_done  = beat_done && (idx == last_idx);
  assign can_load  = !busy || run_done;
  assign en        = !need || can_load;
  assign load      = need && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (run_done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx      <= '0;
      last_idx <= IDX_W'(pc_sat - PC_W'(1));
      pos      <= tail_item.pos;
      bytes    <= tail_par;
    end else if (beat_done) begin
      idx   <= idx + IDX_W'(1);
      bytes <= bytes >> BYTE_W;
    end
  end

  assign out_valid             = busy;
  assign out_beat.parity_index = PIDX_W'(idx);
  assign out_beat.out_pos      = pos;
  assign out_beat.parity_byte  = bytes[0];
  assign out_beat.last         = (idx == last_idx);

endmodule

@@ rtl/core/gf256_parity_shard_encoder_core.sv @@
// gf256_parity_shard_encoder_core: Reed-Solomon parity encoder over GF(2^8), one
// cell per parity row. Depends on gfpse_pkg, gfpse_ifs, gfpse_front, gfpse_cell, gfpse_drain.
//
//  channel     dir  handshake           payload
//  data_in     in   valid/ready         data_byte, shard_index, byte_pos
//  parity_out  out  valid/ready         parity_index, out_pos, parity_byte, last
//  cfg         in   cfg_we              cfg_index, cfg_data (no read-back)
//
// One data beat enters per cycle while the chain is not stalled. Each beat passes an input
// register, a check stage and two stages per cell. A last-shard beat then drains one result
// beat per active parity row, one per cycle while parity_out is ready; while that runs and
// the next such beat reaches the chain end, the whole chain stalls.
// Each cell's accumulator memory has one read and one write a cycle. Reset clears
// pipeline valids and sets 5 data shards, 2 parity shards; accumulators are not cleared.
module gf256_parity_shard_encoder_core #(
  parameter int MAX_DATA_SHARDS   = gfpse_pkg::MAX_DATA_SHARDS_DEF,
  parameter int MAX_PARITY_SHARDS = gfpse_pkg::MAX_PARITY_SHARDS_DEF,
  parameter int SHARD_BYTES       = gfpse_pkg::SHARD_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gfpse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gfpse_pkg::CFG_DATA_W-1:0]   cfg_data,
  gfpse_in_if.sink                           data_in,
  gfpse_out_if.source                        parity_out
);
  import gfpse_pkg::*;

  localparam int PC_W = $clog2(MAX_PARITY_SHARDS + 1);

  logic                                     en;
  logic [DCOUNT_W-1:0]                      num_data;
  logic [PC_W-1:0]                          pc_sat;
  logic [MAX_PARITY_SHARDS-1:0]             row_active;
  item_t                                    chain_item [MAX_PARITY_SHARDS+1];
  logic [MAX_PARITY_SHARDS:0][MAX_PARITY_SHARDS-1:0][BYTE_W-1:0] chain_par;

  assign data_in.ready = en;

  // Config, input register and range check
  gfpse_front #(
    .MAX_DATA_SHARDS   (MAX_DATA_SHARDS),
    .MAX_PARITY_SHARDS (MAX_PARITY_SHARDS),
    .SHARD_BYTES       (SHARD_BYTES),
    .PC_W              (PC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (data_in.valid),
    .in_beat    (data_in.beat),
    .item_out   (chain_item[0]),
    .num_data   (num_data),
    .pc_sat     (pc_sat),
    .row_active (row_active)
  );

  assign chain_par[0] = '0;

  // Row of parity cells
  for (genvar c = 0; c < MAX_PARITY_SHARDS; c++) begin : g_cell
    gfpse_cell #(
      .CELL_IDX          (c),
      .MAX_PARITY_SHARDS (MAX_PARITY_SHARDS),
      .SHARD_BYTES       (SHARD_BYTES)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .active     (row_active[c]),
      .num_data   (num_data),
      .item_in    (chain_item[c]),
      .par_in     (chain_par[c]),
      .item_out   (chain_item[c+1]),
      .par_out    (chain_par[c+1])
    );
  end

  // Result serializer
  gfpse_drain #(
    .MAX_PARITY_SHARDS (MAX_PARITY_SHARDS),
    .PC_W              (PC_W)
  ) u_drain (
    .clk       (clk),
    .rst       (rst),
    .tail_item (chain_item[MAX_PARITY_SHARDS]),
    .tail_par  (chain_par[MAX_PARITY_SHARDS]),
    .pc_sat    (pc_sat),
    .en        (en),
    .out_valid (parity_out.valid),
    .out_ready (parity_out.ready),
    .out_beat  (parity_out.beat)
  );

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking bench for gf256_parity_shard_encoder_core (GF(2^8) parity encoder).
// Uses gfpse_pkg and the gfpse_in_if / gfpse_out_if channels; predicts every parity
// beat in-bench and compares each one against the oldest outstanding prediction.
`timescale 1ns / 1ps

module tb;
  import gfpse_pkg::*;

  localparam int ROWS_MAX  = MAX_PARITY_SHARDS_DEF;
  localparam int POS_COUNT = SHARD_BYTES_DEF;
  localparam int SETTLE    = 40;   // lets the pipeline empty

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gfpse_in_if  data_in ();
  gfpse_out_if parity_out ();

  gf256_parity_shard_encoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_in    (data_in),
    .parity_out (parity_out)
  );

  // Encoder state as the bench sees it
  logic [DCOUNT_W-1:0] enc_dcount;
  logic [PCOUNT_W-1:0] enc_pcount;
  logic [BYTE_W-1:0]   parity_acc [ROWS_MAX][POS_COUNT];
  bit                  acc_started [ROWS_MAX][POS_COUNT];
  out_beat_t           parity_expq [$];
  int                  err_count;
  bit                  no_idle;

  always #1 clk = ~clk;

  // GF(2^8) multiply, shift and reduce by the field polynomial
  function automatic logic [BYTE_W-1:0] gf_times(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
    logic [8:0]        x;
    logic [BYTE_W-1:0] r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) r = r ^ x[7:0];
      x = x << 1;
      if (x[8]) x = x ^ GF_POLY;
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] gf_raise(input logic [BYTE_W-1:0] base, input int n);
    logic [BYTE_W-1:0] r;
    r = 8'h01;
    repeat (n) r = gf_times(r, base);
    return r;
  endfunction

  // The parity shard count saturates at the number of parity cells
  function automatic int active_rows();
    return (int'(enc_pcount) > ROWS_MAX) ? ROWS_MAX : int'(enc_pcount);
  endfunction

  // A position may take a non-zero shard only once shard 0 has seeded every row
  function automatic bit rows_seeded(input logic [POS_W-1:0] pos);
    for (int p = 0; p < active_rows(); p++)
      if (!acc_started[p][pos]) return 1'b0;
    return 1'b1;
  endfunction

  // Accumulate one data beat and queue the parity beats it finishes
  function automatic void predict_parity(input in_beat_t b);
    int                rows;
    logic [BYTE_W-1:0] coef;
    logic [BYTE_W-1:0] prod;
    out_beat_t         r;
    rows = active_rows();
    if (int'(b.shard_index) >= int'(enc_dcount)) return;
    for (int p = 0; p < rows; p++) begin
      coef = 8'(int'(enc_dcount) + p + 1);
      prod = gf_times(b.data_byte, gf_raise(coef, int'(b.shard_index)));
      if (b.shard_index == '0) begin
        parity_acc[p][b.byte_pos]  = prod;
        acc_started[p][b.byte_pos] = 1'b1;
      end else begin
        parity_acc[p][b.byte_pos] = parity_acc[p][b.byte_pos] ^ prod;
      end
    end
    if (int'(b.shard_index) + 1 == int'(enc_dcount)) begin
      for (int p = 0; p < rows; p++) begin
        r.parity_index = PIDX_W'(p);
        r.out_pos      = b.byte_pos;
        r.parity_byte  = parity_acc[p][b.byte_pos];
        r.last         = (p + 1 == rows);
        parity_expq.push_back(r);
      end
    end
  endfunction

  function automatic void check_parity(input out_beat_t got);
    out_beat_t want;
    if (parity_expq.size() == 0) begin
      $display("%0t: unexpected parity beat idx %0d pos %0d byte %02h last %0b", $time,
               got.parity_index, got.out_pos, got.parity_byte, got.last);
      err_count++;
      return;
    end
    want = parity_expq.pop_front();
    if (got.parity_index !== want.parity_index) begin
      $display("%0t: parity_index expected %0d actual %0d", $time,
               want.parity_index, got.parity_index);
      err_count++;
    end
    if (got.out_pos !== want.out_pos) begin
      $display("%0t: out_pos expected %0d actual %0d", $time, want.out_pos, got.out_pos);
      err_count++;
    end
    if (got.parity_byte !== want.parity_byte) begin
      $display("%0t: parity_byte expected %02h actual %02h (row %0d pos %0d)", $time,
               want.parity_byte, got.parity_byte, want.parity_index, want.out_pos);
      err_count++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      err_count++;
    end
  endfunction

  // Sample register writes and both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      enc_dcount = NUM_DATA_RST;
      enc_pcount = NUM_PARITY_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_DATA:   enc_dcount = cfg_data[DCOUNT_W-1:0];
          REG_NUM_PARITY: enc_pcount = cfg_data[PCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (data_in.valid && data_in.ready) predict_parity(data_in.beat);
      if (parity_out.valid && parity_out.ready) check_parity(parity_out.beat);
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    parity_out.ready <= no_idle || ($urandom_range(99) >= 11);
  end

  // Present one data beat and hold it until it is taken; valid stays high afterwards
  task automatic send_beat(input logic [BYTE_W-1:0] dbyte, input int shard,
                           input logic [POS_W-1:0] pos);
    in_beat_t b;
    b.data_byte   = dbyte;
    b.shard_index = SHARD_W'(shard);
    b.byte_pos    = pos;
    while (!no_idle && $urandom_range(99) < 11) begin
      data_in.valid <= 1'b0;
      @(negedge clk);
    end
    data_in.valid <= 1'b1;
    data_in.beat  <= b;
    do @(posedge clk); while (data_in.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Stop sending, wait for every predicted beat, then let the pipeline empty
  task automatic drain_results();
    data_in.valid <= 1'b0;
    @(negedge clk);
    while (parity_expq.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_counts(input int dcount, input int pcount);
    drain_results();
    write_reg(REG_NUM_DATA, CFG_DATA_W'(dcount));
    write_reg(REG_NUM_PARITY, CFG_DATA_W'(pcount));
  endtask

  // Reset counts (5 data, 2 parity), full-scale, zero and single-bit bytes at the top position
  task automatic test_default_counts();
    send_beat(8'hff, 0, 11'h7ff);
    send_beat(8'h00, 1, 11'h7ff);
    send_beat(8'hff, 5, 11'h000);   // shard past the data shard count: dropped
    send_beat(8'hff, 2, 11'h7ff);
    send_beat(8'h80, 3, 11'h7ff);
    send_beat(8'hff, 15, 11'h7ff);  // highest shard index: dropped
    send_beat(8'h01, 4, 11'h7ff);
  endtask

  // One data shard, one parity row: every beat finishes a position
  task automatic test_single_shard();
    set_counts(1, 1);
    send_beat(8'ha5, 0, 11'h555);
    send_beat(8'h5a, 0, 11'h2aa);
  endtask

  // Widest group: 16 data shards, 8 parity rows
  task automatic test_widest_group();
    set_counts(16, 8);
    for (int s = 0; s < 16; s++)
      send_beat((s == 0) ? 8'hff : 8'($urandom_range(255)), s, 11'h000);
  endtask

  task automatic test_odd_counts();
    // zero parity rows: nothing accumulates, nothing comes out
    set_counts(2, 0);
    send_beat(8'hff, 0, 11'd3);
    send_beat(8'hff, 1, 11'd3);
    // parity shard count above the cell count saturates to eight rows
    set_counts(3, 15);
    send_beat(8'h01, 0, 11'd4);
    send_beat(8'h02, 1, 11'd4);
    send_beat(8'h03, 2, 11'd4);
    // zero data shards: every beat is dropped
    set_counts(0, 2);
    send_beat(8'hff, 0, 11'd5);
    // data shard count above the shard limit: accumulates but never finishes
    set_counts(20, 3);
    send_beat(8'hff, 0, 11'd6);
    send_beat(8'h7f, 15, 11'd6);
    set_counts(31, 3);
    send_beat(8'h12, 0, 11'd7);
    send_beat(8'h34, 15, 11'd7);
  endtask

  // Up to three interleaved groups, plus dropped beats, cut-short groups and strays
  task automatic run_random_phase(input int dcount, input int pcount, input int target,
                                  input bit quiet);
    int               counted;
    int               r;
    int               s;
    int               shard;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] grp_pos [3];
    int               grp_next [3];
    bit               grp_open [3];
    counted = 0;
    for (int i = 0; i < 3; i++) grp_open[i] = 1'b0;
    set_counts(dcount, pcount);
    no_idle = quiet;
    while (counted < target) begin
      r = $urandom_range(99);
      s = $urandom_range(2);
      if (r < 80) begin
        // well-formed group, shards in order
        if (!grp_open[s]) begin
          grp_pos[s]  = $urandom_range(1) ? POS_W'($urandom_range(15))
                                          : POS_W'($urandom_range(POS_COUNT - 1));
          grp_next[s] = 0;
          grp_open[s] = 1'b1;
        end
        send_beat(8'($urandom_range(255)), grp_next[s], grp_pos[s]);
        counted++;
        grp_next[s]++;
        if (grp_next[s] >= dcount) grp_open[s] = 1'b0;
      end else if (r < 88) begin
        // out-of-range shard, dropped by the block
        if (dcount < 16)
          send_beat(8'($urandom_range(255)), $urandom_range(15, dcount),
                    POS_W'($urandom_range(POS_COUNT - 1)));
      end else if (r < 94) begin
        // cut a group short: abandon it, or jump straight to the last shard
        if (grp_open[s] && grp_next[s] > 0) begin
          if ($urandom_range(1)) begin
            send_beat(8'($urandom_range(255)), dcount - 1, grp_pos[s]);
            counted++;
          end
          grp_open[s] = 1'b0;
        end
      end else begin
        // stray in-range beat; restart the position if it was never seeded
        pos   = POS_W'($urandom_range(POS_COUNT - 1));
        shard = $urandom_range(dcount - 1, 0);
        if (shard != 0 && !rows_seeded(pos)) shard = 0;
        send_beat(8'($urandom_range(255)), shard, pos);
        counted++;
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_groups();
    run_random_phase(16, 8, 70, 1'b0);
    run_random_phase(1, 1, 40, 1'b0);
    run_random_phase(7, 5'h13, 60, 1'b1);   // bit 4 of the write is dropped: 3 rows
    repeat (4)
      run_random_phase($urandom_range(2, 16),
                       $urandom_range(1, 8) | ($urandom_range(1) << 4), 50, 1'b0);
  endtask

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    data_in.valid    = 1'b0;
    data_in.beat     = '0;
    parity_out.ready = 1'b0;
    no_idle          = 1'b0;
    err_count        = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_default_counts();
    test_single_shard();
    test_widest_group();
    test_odd_counts();
    test_random_groups();

    drain_results();
    if (err_count == 0 && parity_expq.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (parity_expq.size() != 0)
        $display("%0t: %0d parity beats never arrived", $time, parity_expq.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d parity beats outstanding", $time, parity_expq.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/gfpse_pkg.sv
rtl/core/gfpse_ifs.sv
rtl/core/gfpse_front.sv
rtl/core/gfpse_cell.sv
rtl/core/gfpse_drain.sv
rtl/core/gf256_parity_shard_encoder_core.sv
tb/sv/tb.sv
